@@ src/htw_pkg.sv @@
// Shared types and codes for the hierarchical timer wheel.
package htw_pkg;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_START = 2'd1,
		MODE_STOP  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		EV_OK      = 2'd0,
		EV_REJECT  = 2'd1,
		EV_EXPIRED = 2'd2
	} event_t;

	localparam logic [63:0] FAR_CLAMP = 64'h0000_0000_ffff_ffff;
	localparam logic [31:0] MIN_INTERVAL_RST = 32'd512;

	typedef struct packed {
		logic [1:0]  mode;
		logic [4:0]  timer_id;
		logic [31:0] interval;
		logic        periodic;
	} htw_req_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic [4:0] fired_id;
		logic       last;
	} htw_rsp_t;

endpackage

@@ src/htw_req_if.sv @@
// Request channel: valid/ready handshake carrying one command item.
interface htw_req_if;
	logic               valid;
	logic               ready;
	htw_pkg::htw_req_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ src/htw_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one result item.
interface htw_rsp_if;
	logic               valid;
	logic               ready;
	htw_pkg::htw_rsp_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ src/hierarchical_timer_wheel_core.sv @@
// Hierarchical timer wheel core: timer table in RAM, scan sequencer, result register.
// Start places then emits the result, stop or reject only emit; one item at a time.
// Tick: a scan of the pool; idle timers are skipped, active timers go through read,
// distance, placement, ST_REARM for a re-arm and ST_FIRE per fired timer, then ST_END.
// Result emission stalls the scan while the result register is still held.
// Reset: time and all active flags clear at once; min_interval returns to 512.
module hierarchical_timer_wheel_core #(
	parameter int NUM_TIMERS = 32,
	parameter int NEAR_BITS  = 8,
	parameter int LEVEL_BITS = 6,
	parameter int LEVELS     = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	htw_req_if.sink     req,
	htw_rsp_if.source   rsp
);
	import htw_pkg::*;

	localparam int NEAR_SIZE  = 1 << NEAR_BITS;
	localparam int LEVEL_SIZE = 1 << LEVEL_BITS;
	localparam int SLOT_W     = $clog2(NEAR_SIZE + LEVELS * LEVEL_SIZE);
	localparam int AW         = NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1;
	localparam int IW         = $clog2(NUM_TIMERS + 1);
	localparam logic [63:0] LVL_MASK = 64'(LEVEL_SIZE - 1);

	typedef struct packed {
		logic [63:0]       expiry;
		logic [31:0]       period;
		logic              rep;
		logic [SLOT_W-1:0] slot;
	} ent_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SPLACE, ST_EMIT, ST_SCAN, ST_DATA, ST_CASC, ST_REARM, ST_FIRE, ST_END
	} state_t;

	// Slot choice from expiry, distance, clamped expiry and low bits of now.
	function automatic logic [SLOT_W-1:0] place_slot(input logic [63:0] e,
			input logic [63:0] d, input logic [63:0] alt,
			input logic [NEAR_BITS-1:0] nr);
		logic [SLOT_W-1:0] s;
		logic [63:0]       ec;
		ec = (d > FAR_CLAMP) ? alt : e;
		s = SLOT_W'(NEAR_SIZE + (LEVELS - 1) * LEVEL_SIZE)
			+ SLOT_W'((ec >> (NEAR_BITS + (LEVELS - 1) * LEVEL_BITS)) & LVL_MASK);
		if (d[63]) begin
			s = SLOT_W'(nr);
		end
		for (int n = LEVELS - 2; n >= 0; n--) begin
			if (d < (64'd1 << (NEAR_BITS + (n + 1) * LEVEL_BITS))) begin
				s = SLOT_W'(NEAR_SIZE + n * LEVEL_SIZE)
					+ SLOT_W'((e >> (NEAR_BITS + n * LEVEL_BITS)) & LVL_MASK);
			end
		end
		if (d < 64'(NEAR_SIZE)) begin
			s = SLOT_W'(e[NEAR_BITS-1:0]);
		end
		return s;
	endfunction

	state_t                state_q;
	logic [31:0]           min_q;
	logic [63:0]           time_q;
	logic [NUM_TIMERS-1:0] active_q;
	logic [IW-1:0]         idx_q;
	logic [4:0]            id_q;
	logic [AW-1:0]         addr_q;

	// Placement operand registers
	logic [63:0]           pl_exp_q, pl_dist_q, pl_alt_q;
	logic [NEAR_BITS-1:0]  pl_near_q;
	ent_t                  ent_q;
	logic                  casc_q;

	// Pending fired timer (its last flag is known only at the next fire or scan end)
	logic                  pend_v_q;
	logic [4:0]            pend_id_q;
	logic [1:0]            res_ev_q;

	logic                  out_v_q;
	htw_rsp_t              out_q;

	// Timer table memory
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	ent_t                  ram_wdata, ram_rdata;
	logic [AW-1:0]         ram_raddr;

	htw_ram #(.WIDTH($bits(ent_t)), .DEPTH(NUM_TIMERS)) u_tab (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic [SLOT_W-1:0] pl_slot;
	logic              out_free;
	logic              out_load;
	logic              near0;
	logic              casc_hit;
	logic              fire;
	logic [SLOT_W-1:0] slot1;
	logic [63:0]       now1;

	assign pl_slot  = place_slot(pl_exp_q, pl_dist_q, pl_alt_q, pl_near_q);
	assign out_free = !out_v_q || rsp.ready;
	assign near0    = (time_q[NEAR_BITS-1:0] == '0);
	assign now1     = time_q + 64'd1;
	assign slot1    = casc_q ? pl_slot : ent_q.slot;
	assign fire     = (slot1 == SLOT_W'(time_q[NEAR_BITS-1:0]));

	// Result register loads a new item this cycle
	assign out_load = out_free && ((state_q == ST_EMIT)
		|| (pend_v_q && (state_q == ST_FIRE || state_q == ST_END)));

	// Cascade hit: entry sits in a cascade slot that this tick empties
	always_comb begin
		logic go;
		go       = near0;
		casc_hit = 1'b0;
		for (int n = 0; n < LEVELS; n++) begin
			if (go && ram_rdata.slot == SLOT_W'(NEAR_SIZE + n * LEVEL_SIZE)
					+ SLOT_W'((time_q >> (NEAR_BITS + n * LEVEL_BITS)) & LVL_MASK)) begin
				casc_hit = 1'b1;
			end
			if (((time_q >> (NEAR_BITS + n * LEVEL_BITS)) & LVL_MASK) != 64'd0) begin
				go = 1'b0;
			end
		end
	end

	// Table write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = ent_q;
		ram_raddr = idx_q[AW-1:0];
		unique case (state_q)
			ST_SPLACE: begin
				ram_we         = 1'b1;
				ram_wdata.expiry = pl_exp_q;
				ram_wdata.slot = pl_slot;
			end
			ST_CASC: begin
				ram_we         = !(fire && ent_q.rep) && casc_q;
				ram_wdata.slot = slot1;
			end
			ST_REARM: begin
				ram_we           = 1'b1;
				ram_wdata.expiry = pl_exp_q;
				ram_wdata.slot   = pl_slot;
			end
			default: ram_we = 1'b0;
		endcase
	end

	assign req.ready  = (state_q == ST_IDLE);
	assign rsp.valid  = out_v_q;
	assign rsp.data   = out_q;

	// Sequencer, state registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			min_q    <= MIN_INTERVAL_RST;
			time_q   <= '0;
			active_q <= '0;
			idx_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				min_q <= cfg_wdata;
			end
			if (out_v_q && rsp.ready && !out_load) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						id_q   <= req.data.timer_id;
						addr_q <= AW'(req.data.timer_id);
						unique case (mode_t'(req.data.mode))
							MODE_TICK: begin
								idx_q    <= '0;
								pend_v_q <= 1'b0;
								state_q  <= ST_SCAN;
							end
							MODE_NONE: state_q <= ST_IDLE;
							default: begin
								if (32'(req.data.timer_id) >= 32'(NUM_TIMERS)) begin
									res_ev_q <= EV_REJECT;
									state_q  <= ST_EMIT;
								end else begin
									active_q[AW'(req.data.timer_id)] <= 1'b0;
									if (req.data.mode == MODE_STOP) begin
										res_ev_q <= EV_OK;
										state_q  <= ST_EMIT;
									end else if (req.data.interval < min_q) begin
										res_ev_q <= EV_REJECT;
										state_q  <= ST_EMIT;
									end else begin
										ent_q.period <= req.data.interval;
										ent_q.rep    <= req.data.periodic;
										pl_exp_q     <= time_q + 64'(req.data.interval);
										pl_dist_q    <= 64'(req.data.interval);
										pl_alt_q     <= time_q + FAR_CLAMP;
										pl_near_q    <= time_q[NEAR_BITS-1:0];
										res_ev_q     <= EV_OK;
										state_q      <= ST_SPLACE;
									end
								end
							end
						endcase
					end
				end
				ST_SPLACE: begin
					active_q[addr_q] <= 1'b1;
					state_q          <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_v_q         <= 1'b1;
						out_q.event_res <= res_ev_q;
						out_q.fired_id  <= id_q;
						out_q.last      <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				// Walk the pool; idle timers are skipped here
				ST_SCAN: begin
					if (idx_q == IW'(NUM_TIMERS)) begin
						state_q <= ST_END;
					end else if (!active_q[idx_q[AW-1:0]]) begin
						idx_q <= idx_q + IW'(1);
					end else begin
						addr_q  <= idx_q[AW-1:0];
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					ent_q     <= ram_rdata;
					casc_q    <= casc_hit;
					pl_exp_q  <= ram_rdata.expiry;
					pl_dist_q <= ram_rdata.expiry - time_q;
					pl_alt_q  <= time_q + FAR_CLAMP;
					pl_near_q <= time_q[NEAR_BITS-1:0];
					state_q   <= ST_CASC;
				end
				// Cascade placement and fire decision
				ST_CASC: begin
					ent_q.slot <= slot1;
					if (fire && ent_q.rep) begin
						pl_exp_q  <= time_q + 64'(ent_q.period);
						pl_dist_q <= 64'(ent_q.period) - 64'd1;
						pl_alt_q  <= now1 + FAR_CLAMP;
						pl_near_q <= now1[NEAR_BITS-1:0];
						state_q   <= ST_REARM;
					end else if (fire) begin
						active_q[addr_q] <= 1'b0;
						state_q          <= ST_FIRE;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_REARM: state_q <= ST_FIRE;
				ST_FIRE: begin
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_v_q         <= 1'b1;
							out_q.event_res <= EV_EXPIRED;
							out_q.fired_id  <= pend_id_q;
							out_q.last      <= 1'b0;
						end
						pend_v_q  <= 1'b1;
						pend_id_q <= 5'(idx_q);
						idx_q     <= idx_q + IW'(1);
						state_q   <= ST_SCAN;
					end
				end
				ST_END: begin
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_v_q         <= 1'b1;
							out_q.event_res <= EV_EXPIRED;
							out_q.fired_id  <= pend_id_q;
							out_q.last      <= 1'b1;
						end
						pend_v_q <= 1'b0;
						time_q   <= now1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ src/htw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module htw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
